FILE: hdl/kzmc_pkg.sv
// ----------------------------------------------------------------------------
// kzmc_pkg
// Shared types and constants for the keepout zone move clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package kzmc_pkg;

  localparam int CoordW      = 24;
  localparam int CornerW     = 23;
  localparam int DiffW       = 25;
  localparam int MarginUnits = 128;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 23;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARMED  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AX     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AY     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BX     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BY     = 3'd5;

  // message codes
  localparam logic [2:0] MSG_NONE   = 3'd0;
  localparam logic [2:0] MSG_INSIDE = 3'd1;
  localparam logic [2:0] MSG_TARGET = 3'd2;
  localparam logic [2:0] MSG_CROSS  = 3'd3;
  localparam logic [2:0] MSG_WALL   = 3'd4;

  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] goal_x;
    logic signed [CoordW-1:0] goal_y;
  } kzmc_in_t;

  typedef struct packed {
    logic                     blocked;
    logic [2:0]               message_code;
    logic signed [CoordW-1:0] result_x;
    logic signed [CoordW-1:0] result_y;
    logic                     other_axes_held;
  } kzmc_out_t;

  // classified move handed from front to back
  typedef struct packed {
    logic                     active;
    logic                     mode;
    logic                     strict;
    logic                     tech;
    logic                     deep;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] goal_x;
    logic signed [CoordW-1:0] goal_y;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [DiffW-1:0]  q0;
    logic signed [DiffW-1:0]  q1;
    logic signed [DiffW-1:0]  q2;
    logic signed [DiffW-1:0]  q3;
  } kzmc_cls_t;

endpackage

`default_nettype wire

FILE: hdl/keepout_zone_move_clipper_core.sv
// ----------------------------------------------------------------------------
// keepout_zone_move_clipper_core
// Clips XY moves against a rectangular keepout zone (Liang-Barsky).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one move word per valid/ready handshake (mode, start, goal).
//   out_* : one result word per move, in order, valid/ready.
//   cfg_* : register writes (enable, arm, two corners), one per cycle with
//           cfg_we high; write only while no move is in flight.
// Dividers: each edge divider resolves one quotient bit per stage; a move
//   passes the front register, the queue, the divider stages, then the
//   combine, multiply and output registers.
// Throughput: one move per cycle while out_ready stays high; all stages of
//   the back end advance together, so every such cycle can take a new word.
// Structure: the front registers one classified word and hands it to a
//   two-word queue; the back end (dividers, combine, multiply, output
//   register) drains it. A stalled receiver freezes the back end, the
//   queue fills, then in_ready falls. Nothing is dropped.
// Reset (sync, active low): empties all stages, zone disabled and disarmed,
//   corners back to 10 mm / 50 mm.
// ----------------------------------------------------------------------------
`default_nettype none

module keepout_zone_move_clipper_core #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [kzmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [kzmc_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kzmc_pkg::kzmc_in_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output kzmc_pkg::kzmc_out_t                out_data
);
  import kzmc_pkg::*;

  // front -> queue
  logic      f_valid, f_ready;
  kzmc_cls_t f_data;
  // queue -> back
  logic      b_valid, b_ready;
  kzmc_cls_t b_data;

  kzmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  kzmc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  kzmc_back #(.PF(PARAM_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (b_valid),
    .cls_ready (b_ready),
    .cls_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/kzmc_front.sv
// ----------------------------------------------------------------------------
// kzmc_front
// Zone registers, corner sort, inside tests and edge distances; one register.
// ----------------------------------------------------------------------------
`default_nettype none

module kzmc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [kzmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [kzmc_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kzmc_pkg::kzmc_in_t            in_data,
  output logic                               cls_valid,
  input  wire logic                          cls_ready,
  output kzmc_pkg::kzmc_cls_t                cls_data
);
  import kzmc_pkg::*;

  localparam int CmpW = DiffW + 1;

  logic                      enable_r, armed_r;
  logic signed [CornerW-1:0] ax_r, ay_r, bx_r, by_r;
  logic                      v_r;
  kzmc_cls_t                 cls_r, cls_nxt;

  logic signed [CornerW-1:0] xl, xh, yl, yh;
  logic signed [CmpW-1:0]    xlm, xhm, ylm, yhm, sx, sy, gx, gy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      armed_r  <= 1'b0;
      ax_r     <= 23'sd2560;
      ay_r     <= 23'sd2560;
      bx_r     <= 23'sd12800;
      by_r     <= 23'sd12800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_ARMED:  armed_r  <= cfg_wdata[0];
        CFG_AX:     ax_r     <= cfg_wdata;
        CFG_AY:     ay_r     <= cfg_wdata;
        CFG_BX:     bx_r     <= cfg_wdata;
        CFG_BY:     by_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    xl  = (ax_r < bx_r) ? ax_r : bx_r;
    xh  = (ax_r < bx_r) ? bx_r : ax_r;
    yl  = (ay_r < by_r) ? ay_r : by_r;
    yh  = (ay_r < by_r) ? by_r : ay_r;
    xlm = CmpW'(xl) + CmpW'(MarginUnits);
    xhm = CmpW'(xh) - CmpW'(MarginUnits);
    ylm = CmpW'(yl) + CmpW'(MarginUnits);
    yhm = CmpW'(yh) - CmpW'(MarginUnits);
    sx  = CmpW'(in_data.start_x);
    sy  = CmpW'(in_data.start_y);
    gx  = CmpW'(in_data.goal_x);
    gy  = CmpW'(in_data.goal_y);

    cls_nxt.active  = enable_r & armed_r;
    cls_nxt.mode    = in_data.mode;
    cls_nxt.strict  = (sx > xlm) && (sx < xhm) && (sy > ylm) && (sy < yhm);
    cls_nxt.tech    = (sx >= CmpW'(xl)) && (sx <= CmpW'(xh)) &&
                      (sy >= CmpW'(yl)) && (sy <= CmpW'(yh));
    cls_nxt.deep    = (gx > xlm) && (gx < xhm) && (gy > ylm) && (gy < yhm);
    cls_nxt.start_x = in_data.start_x;
    cls_nxt.start_y = in_data.start_y;
    cls_nxt.goal_x  = in_data.goal_x;
    cls_nxt.goal_y  = in_data.goal_y;
    cls_nxt.dx      = DiffW'(in_data.goal_x) - DiffW'(in_data.start_x);
    cls_nxt.dy      = DiffW'(in_data.goal_y) - DiffW'(in_data.start_y);
    cls_nxt.q0      = DiffW'(in_data.start_x) - DiffW'(xl);
    cls_nxt.q1      = DiffW'(xh) - DiffW'(in_data.start_x);
    cls_nxt.q2      = DiffW'(in_data.start_y) - DiffW'(yl);
    cls_nxt.q3      = DiffW'(yh) - DiffW'(in_data.start_y);
  end

  assign in_ready  = !v_r || cls_ready;
  assign cls_valid = v_r;
  assign cls_data  = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kzmc_fifo.sv
// ----------------------------------------------------------------------------
// kzmc_fifo
// Two-entry queue of classified moves between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module kzmc_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire kzmc_pkg::kzmc_cls_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output kzmc_pkg::kzmc_cls_t      pop_data
);
  import kzmc_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  kzmc_cls_t       mem_r [Depth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;
  logic            push, pop;

  assign push_ready = cnt_r != CntW'(Depth);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PtrW'(1);
      if (pop)  rd_r <= rd_r + PtrW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CntW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kzmc_div.sv
// ----------------------------------------------------------------------------
// kzmc_div
// Pipelined floor divide t = floor(num * 2^PF / den), saturated to [-1, 2].
// ----------------------------------------------------------------------------
`default_nettype none

module kzmc_div #(
  parameter int PF = 16
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [kzmc_pkg::DiffW-1:0]   num,
  input  wire logic signed [kzmc_pkg::DiffW:0]     den,
  output logic signed [PF+2:0]                     t_o
);
  import kzmc_pkg::*;

  localparam int QB = PF + 2;          // quotient bits, one per stage
  localparam int TW = PF + 3;
  localparam int NW = DiffW + PF;      // |num| << PF
  localparam int DW = DiffW;           // |den| <= 2^24
  localparam int CW = NW + 2;
  localparam logic [QB-1:0]   QMax  = QB'(1) << (PF + 1);
  localparam logic [QB:0]     QMinN = (QB + 1)'(1) << PF;
  localparam logic [TW-1:0]   TMax  = TW'(1) << (PF + 1);

  logic [NW-1:0] r_r   [QB];
  logic [DW-1:0] d_r   [QB];
  logic [QB-1:0] qt_r  [QB];
  logic          neg_r [QB];
  logic          ovf_r [QB];

  logic [NW-1:0] r_in  [QB];
  logic [DW-1:0] d_in  [QB];
  logic [QB-1:0] qt_in [QB];
  logic          neg_in[QB];
  logic          ovf_in[QB];

  logic [DiffW-1:0] nmag;
  logic [DiffW:0]   dmag;

  assign nmag = num[DiffW-1] ? DiffW'(-num) : DiffW'(num);
  assign dmag = den[DiffW] ? (DiffW + 1)'(-den) : (DiffW + 1)'(den);

  assign r_in[0]   = {nmag, PF'(0)};
  assign d_in[0]   = dmag[DW-1:0];
  assign qt_in[0]  = '0;
  assign neg_in[0] = num[DiffW-1] ^ den[DiffW];
  assign ovf_in[0] = CW'({nmag, PF'(0)}) >= (CW'(dmag[DW-1:0]) << QB);

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [CW-1:0] trial;
    logic          take;
    logic [QB-1:0] qt_nxt;

    if (s > 0) begin : g_link
      assign r_in[s]   = r_r[s-1];
      assign d_in[s]   = d_r[s-1];
      assign qt_in[s]  = qt_r[s-1];
      assign neg_in[s] = neg_r[s-1];
      assign ovf_in[s] = ovf_r[s-1];
    end

    always_comb begin
      trial     = CW'(d_in[s]) << K;
      take      = CW'(r_in[s]) >= trial;
      qt_nxt    = qt_in[s];
      qt_nxt[K] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s]   <= take ? NW'(CW'(r_in[s]) - trial) : r_in[s];
        d_r[s]   <= d_in[s];
        qt_r[s]  <= qt_nxt;
        neg_r[s] <= neg_in[s];
        ovf_r[s] <= ovf_in[s];
      end
    end
  end

  logic [QB:0]   mag;
  logic [TW-1:0] t_nxt;

  always_comb begin
    mag = (QB + 1)'(qt_r[QB-1]) + (QB + 1)'(r_r[QB-1] != '0);
    if (!neg_r[QB-1]) begin
      t_nxt = (ovf_r[QB-1] || qt_r[QB-1] > QMax) ? TMax : TW'(qt_r[QB-1]);
    end else if (ovf_r[QB-1] || mag > QMinN) begin
      t_nxt = -(TW'(1) << PF);
    end else begin
      t_nxt = -TW'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_o <= t_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kzmc_back.sv
// ----------------------------------------------------------------------------
// kzmc_back
// Edge divides, entry/exit parameter combine, clip multiply, decision.
// ----------------------------------------------------------------------------
`default_nettype none

module kzmc_back #(
  parameter int PF = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cls_valid,
  output logic                     cls_ready,
  input  wire kzmc_pkg::kzmc_cls_t cls_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output kzmc_pkg::kzmc_out_t      out_data
);
  import kzmc_pkg::*;

  localparam int TW = PF + 3;
  localparam int DL = PF + 3;          // divider latency
  localparam int PW = TW + DiffW;
  localparam logic signed [TW-1:0] TOne = TW'(1) << PF;
  localparam logic signed [PW-1:0] Half = PW'(1) << (PF - 1);

  logic en;
  assign en        = !out_valid || out_ready;
  assign cls_ready = en;

  // sideband alongside the dividers
  kzmc_cls_t sb_r  [DL];
  logic      vld_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= cls_valid;
      for (int i = 1; i < DL; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= cls_data;
      for (int i = 1; i < DL; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  logic signed [DiffW-1:0] num_w [4];
  logic signed [DiffW:0]   den_w [4];
  logic signed [TW-1:0]    t_w   [4];

  assign num_w[0] = cls_data.q0;
  assign num_w[1] = cls_data.q1;
  assign num_w[2] = cls_data.q2;
  assign num_w[3] = cls_data.q3;
  assign den_w[0] = -(DiffW + 1)'(cls_data.dx);
  assign den_w[1] = (DiffW + 1)'(cls_data.dx);
  assign den_w[2] = -(DiffW + 1)'(cls_data.dy);
  assign den_w[3] = (DiffW + 1)'(cls_data.dy);

  for (genvar i = 0; i < 4; i++) begin : g_div
    kzmc_div #(.PF(PF)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_w[i]),
      .den (den_w[i]),
      .t_o (t_w[i])
    );
  end

  // combine: walk the left, right, bottom and top edges in order
  kzmc_cls_t            hd;
  logic [3:0]           pz, pn, qn;
  logic                 ok, hits;
  logic signed [TW-1:0] t0, t1;

  always_comb begin
    hd    = sb_r[DL-1];
    pz[0] = hd.dx == '0;
    pz[1] = hd.dx == '0;
    pz[2] = hd.dy == '0;
    pz[3] = hd.dy == '0;
    pn[0] = hd.dx > 0;
    pn[1] = hd.dx < 0;
    pn[2] = hd.dy > 0;
    pn[3] = hd.dy < 0;
    qn[0] = hd.q0 < 0;
    qn[1] = hd.q1 < 0;
    qn[2] = hd.q2 < 0;
    qn[3] = hd.q3 < 0;
    ok = 1'b1;
    t0 = '0;
    t1 = TOne;
    for (int i = 0; i < 4; i++) begin
      if (ok) begin
        if (pz[i]) begin
          if (qn[i]) ok = 1'b0;
        end else if (pn[i]) begin
          if (t_w[i] > t1)      ok = 1'b0;
          else if (t_w[i] > t0) t0 = t_w[i];
        end else begin
          if (t_w[i] < t0)      ok = 1'b0;
          else if (t_w[i] < t1) t1 = t_w[i];
        end
      end
    end
    hits = ok && (t0 < t1);
  end

  kzmc_cls_t            c_sb_r;
  logic                 c_v_r, c_ok_r, c_hit_r;
  logic signed [TW-1:0] c_t0_r;

  kzmc_cls_t            m_sb_r;
  logic                 m_v_r, m_hit_r, m_clip_r;
  logic signed [PW-1:0] m_px_r, m_py_r;

  logic      out_v_r;
  kzmc_out_t out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      c_v_r   <= vld_r[DL-1];
      m_v_r   <= c_v_r;
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sb_r   <= hd;
      c_ok_r   <= ok;
      c_hit_r  <= hits;
      c_t0_r   <= t0;
      m_sb_r   <= c_sb_r;
      m_hit_r  <= c_hit_r;
      m_clip_r <= c_ok_r && (c_t0_r > 0);
      m_px_r   <= PW'(c_t0_r) * PW'(c_sb_r.dx);
      m_py_r   <= PW'(c_t0_r) * PW'(c_sb_r.dy);
      out_r    <= out_nxt;
    end
  end

  // decision and rounded entry point
  logic signed [PW-1:0]     sum_x, sum_y;
  logic signed [CoordW-1:0] clip_x, clip_y;

  always_comb begin
    sum_x  = (m_px_r + Half) >>> PF;
    sum_y  = (m_py_r + Half) >>> PF;
    clip_x = m_sb_r.start_x + sum_x[CoordW-1:0];
    clip_y = m_sb_r.start_y + sum_y[CoordW-1:0];

    out_nxt.blocked         = 1'b0;
    out_nxt.message_code    = MSG_NONE;
    out_nxt.result_x        = m_sb_r.goal_x;
    out_nxt.result_y        = m_sb_r.goal_y;
    out_nxt.other_axes_held = 1'b0;
    if (m_sb_r.active) begin
      if (!m_sb_r.mode) begin
        if (m_sb_r.deep) begin
          out_nxt.blocked      = 1'b1;
          out_nxt.message_code = m_sb_r.tech ? MSG_INSIDE : MSG_TARGET;
        end else if (m_hit_r) begin
          out_nxt.blocked      = 1'b1;
          out_nxt.message_code = m_sb_r.tech ? MSG_INSIDE : MSG_CROSS;
        end
      end else if (m_sb_r.strict) begin
        out_nxt.blocked         = 1'b1;
        out_nxt.message_code    = MSG_INSIDE;
        out_nxt.result_x        = m_sb_r.start_x;
        out_nxt.result_y        = m_sb_r.start_y;
        out_nxt.other_axes_held = 1'b1;
      end else if (m_sb_r.deep || m_hit_r) begin
        out_nxt.blocked      = 1'b1;
        out_nxt.message_code = m_sb_r.tech ? MSG_INSIDE : MSG_WALL;
        if (m_clip_r) begin
          out_nxt.result_x = clip_x;
          out_nxt.result_y = clip_y;
        end else begin
          out_nxt.result_x        = m_sb_r.start_x;
          out_nxt.result_y        = m_sb_r.start_y;
          out_nxt.other_axes_held = 1'b1;
        end
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: sim/tb_keepout_zone_move_clipper_core.sv
// ----------------------------------------------------------------------------
// tb_keepout_zone_move_clipper_core
// Self-checking bench for the keepout zone move clipper core. A driver sends
// move words from a queue, an in-bench clipper predicts each result word, and
// a monitor compares the block's results, in order, field by field. Several
// zone settings are used, written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keepout_zone_move_clipper_core;
  import kzmc_pkg::*;

  localparam int TFrac    = 16;
  localparam int Latency  = TFrac + 7;
  localparam longint TOne = 64'sd1 <<< TFrac;
  localparam int MaxCycles = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_ENABLE;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  kzmc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kzmc_out_t out_data;

  keepout_zone_move_clipper_core #(.PARAM_FRAC_BITS(TFrac)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // zone settings as the block should hold them
  logic zone_en, zone_arm;
  logic signed [CornerW-1:0] cax, cay, cbx, cby;

  kzmc_in_t  move_queue[$];     // words waiting for the driver
  kzmc_out_t expected_clips[$]; // predicted results, oldest first

  int  errors = 0;
  int  cycles = 0;
  int  sent = 0;
  int  checked = 0;
  int  send_idle_pct = 0;   // per-cycle idle odds, percent
  int  recv_idle_pct = 0;
  int  hold_off = 0;        // long receiver stall, cycles left
  bit  hold_req = 0;
  bit  hold_done = 0;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic bit deep_in(longint x, longint y, longint xl, longint xh,
                                 longint yl, longint yh);
    return x > xl + MarginUnits && x < xh - MarginUnits &&
           y > yl + MarginUnits && y < yh - MarginUnits;
  endfunction

  // predicted result of one move under the current zone setting
  function automatic kzmc_out_t clip_move(kzmc_in_t m);
    kzmc_out_t r;
    longint x0, y0, xt, yt, xl, xh, yl, yh, dx, dy, t0, t1, t;
    longint p[4], q[4];
    bit ok, strict, tech, deep, hits;
    x0 = m.start_x; y0 = m.start_y; xt = m.goal_x; yt = m.goal_y;
    xl = (cax < cbx) ? cax : cbx; xh = (cax < cbx) ? cbx : cax;
    yl = (cay < cby) ? cay : cby; yh = (cay < cby) ? cby : cay;
    r = '0;
    r.result_x = m.goal_x;
    r.result_y = m.goal_y;
    if (!(zone_en && zone_arm)) return r;
    dx = xt - x0; dy = yt - y0;
    strict = deep_in(x0, y0, xl, xh, yl, yh);
    deep   = deep_in(xt, yt, xl, xh, yl, yh);
    tech   = x0 >= xl && x0 <= xh && y0 >= yl && y0 <= yh;
    p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
    q[0] = x0 - xl; q[1] = xh - x0; q[2] = y0 - yl; q[3] = yh - y0;
    t0 = 0; t1 = TOne; ok = 1;
    // Liang-Barsky edge walk; stops at the first rejecting edge
    for (int i = 0; i < 4; i++) begin
      if (!ok) continue;
      if (p[i] == 0) begin
        if (q[i] < 0) ok = 0;
      end else begin
        t = fdiv(q[i] * TOne, p[i]);
        if (t < -TOne) t = -TOne;
        if (t > 2 * TOne) t = 2 * TOne;
        if (p[i] < 0) begin
          if (t > t1) ok = 0;
          else if (t > t0) t0 = t;
        end else begin
          if (t < t0) ok = 0;
          else if (t < t1) t1 = t;
        end
      end
    end
    hits = ok && t0 < t1;
    if (!m.mode) begin
      if (deep) begin
        r.blocked = 1; r.message_code = tech ? MSG_INSIDE : MSG_TARGET;
      end else if (hits) begin
        r.blocked = 1; r.message_code = tech ? MSG_INSIDE : MSG_CROSS;
      end
    end else if (strict) begin
      r.blocked = 1; r.message_code = MSG_INSIDE;
      r.result_x = m.start_x; r.result_y = m.start_y; r.other_axes_held = 1;
    end else if (deep || hits) begin
      r.blocked = 1;
      r.message_code = tech ? MSG_INSIDE : MSG_WALL;
      if (ok && t0 > 0) begin
        // entry point, rounded to nearest, ties up
        r.result_x = CoordW'(x0 + fdiv(t0 * dx + TOne / 2, TOne));
        r.result_y = CoordW'(y0 + fdiv(t0 * dy + TOne / 2, TOne));
      end else begin
        r.result_x = m.start_x; r.result_y = m.start_y; r.other_axes_held = 1;
      end
    end
    return r;
  endfunction

  // driver: one word on offer at a time, held until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_clips.push_back(clip_move(in_data));
        sent++;
      end
      if ((!in_valid || in_ready) && move_queue.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data  <= move_queue.pop_front();
        in_valid <= 1'b1;
      end else if (!in_valid || in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (hold_req && !hold_done) begin
      hold_off  <= 200;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor plus receiver stall control
  always @(posedge clk) begin
    kzmc_out_t exp_w;
    cycles++;
    if (cycles > MaxCycles) begin
      $display("%0t: timeout, %0d results still due", $time, expected_clips.size());
      $display("Mismatches found");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_clips.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_data);
          errors++;
        end else begin
          exp_w = expected_clips.pop_front();
          checked++;
          if (out_data.blocked !== exp_w.blocked)
            $display("%0t: blocked exp %0b got %0b", $time, exp_w.blocked,
                     out_data.blocked);
          if (out_data.message_code !== exp_w.message_code)
            $display("%0t: message_code exp %0d got %0d", $time,
                     exp_w.message_code, out_data.message_code);
          if (out_data.result_x !== exp_w.result_x)
            $display("%0t: result_x exp %0d got %0d", $time, exp_w.result_x,
                     out_data.result_x);
          if (out_data.result_y !== exp_w.result_y)
            $display("%0t: result_y exp %0d got %0d", $time, exp_w.result_y,
                     out_data.result_y);
          if (out_data.other_axes_held !== exp_w.other_axes_held)
            $display("%0t: other_axes_held exp %0b got %0b", $time,
                     exp_w.other_axes_held, out_data.other_axes_held);
          if (out_data !== exp_w) errors++;
        end
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: zone_en  = val[0];
      CFG_ARMED:  zone_arm = val[0];
      CFG_AX:     cax = val;
      CFG_AY:     cay = val;
      CFG_BX:     cbx = val;
      CFG_BY:     cby = val;
      default: ;
    endcase
  endtask

  task automatic set_zone(logic en, logic arm, int ax, int ay, int bx, int by);
    write_reg(CFG_ENABLE, CfgDataW'(en));
    write_reg(CFG_ARMED, CfgDataW'(arm));
    write_reg(CFG_AX, CfgDataW'(ax));
    write_reg(CFG_AY, CfgDataW'(ay));
    write_reg(CFG_BX, CfgDataW'(bx));
    write_reg(CFG_BY, CfgDataW'(by));
  endtask

  // wait for every result, then let the pipe run empty
  task automatic drain();
    while (move_queue.size() > 0 || in_valid || expected_clips.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic kzmc_in_t mk(bit md, int sx, int sy, int gx, int gy);
    kzmc_in_t m;
    m.mode    = md;
    m.start_x = CoordW'(sx);
    m.start_y = CoordW'(sy);
    m.goal_x  = CoordW'(gx);
    m.goal_y  = CoordW'(gy);
    return m;
  endfunction

  function automatic int near_coord(int lo, int hi);
    case ($urandom_range(4))
      0: return lo + $signed($urandom_range(300)) - 150;
      1: return hi + $signed($urandom_range(300)) - 150;
      2: return lo + $urandom_range(hi > lo ? hi - lo : lo - hi);
      3: return $signed($urandom_range(8000000)) - 4000000;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic kzmc_in_t random_move();
    int xl, xh, yl, yh;
    xl = (cax < cbx) ? cax : cbx; xh = (cax < cbx) ? cbx : cax;
    yl = (cay < cby) ? cay : cby; yh = (cay < cby) ? cby : cay;
    if ($urandom_range(9) == 0) return kzmc_in_t'({$urandom, $urandom, $urandom, $urandom});
    return mk($urandom_range(1), near_coord(xl, xh), near_coord(yl, yh),
              near_coord(xl, xh), near_coord(yl, yh));
  endfunction

  task automatic random_batch(int n);
    repeat (n) move_queue.push_back(random_move());
  endtask

  initial begin
    zone_en = 0; zone_arm = 0;
    cax = 2560; cay = 2560; cbx = 12800; cby = 12800;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zone off at reset: everything passes
    move_queue.push_back(mk(1, 5000, 5000, 6000, 6000));
    move_queue.push_back(mk(0, 0, 0, 8000, 8000));
    drain();

    set_zone(1, 1, 2560, 2560, 12800, 12800);
    // directed: strict start, deep target, crossing, wall clip, edge start,
    // zero-length move, axis-parallel move, field extremes
    move_queue.push_back(mk(1, 5000, 5000, 20000, 5000));
    move_queue.push_back(mk(0, 0, 5000, 6000, 6000));
    move_queue.push_back(mk(0, 0, 5000, 20000, 5000));
    move_queue.push_back(mk(1, 0, 5000, 20000, 5000));
    move_queue.push_back(mk(1, 0, 0, 7000, 7000));
    move_queue.push_back(mk(1, 2560, 5000, 0, 5000));
    move_queue.push_back(mk(1, 2560, 5000, 6000, 5000));
    move_queue.push_back(mk(0, 2600, 2600, 6000, 6000));
    move_queue.push_back(mk(1, 5000, 5000, 5000, 5000));
    move_queue.push_back(mk(1, 0, 0, 0, 0));
    move_queue.push_back(mk(0, 5000, 0, 5000, 20000));
    move_queue.push_back(mk(1, 5000, 0, 5000, 20000));
    move_queue.push_back(mk(1, -8388608, -8388608, 8388607, 8388607));
    move_queue.push_back(mk(0, 8388607, 8388607, -8388608, -8388608));
    move_queue.push_back(mk(1, -8388608, 8388607, 8388607, -8388608));
    move_queue.push_back(mk(1, 2689, 2689, 2688, 2688));
    move_queue.push_back(mk(0, 0, 12800, 20000, 12800));
    move_queue.push_back(mk(1, 20000, 20000, 30000, 30000));
    drain();

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 7; recv_idle_pct = 74;
    random_batch(150);
    drain();

    // inverted corners, then widest zone at the corner extremes
    set_zone(1, 1, 12800, -4000, -3000, 2560);
    send_idle_pct = 74; recv_idle_pct = 7;
    random_batch(120);
    drain();
    set_zone(1, 1, -4194304, 4194303, 4194303, -4194304);
    random_batch(80);
    drain();

    // collapsed zone, then no idling with a long receiver stall
    set_zone(1, 1, 5000, 1000, 5000, 9000);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_batch(60);
    hold_req = 1;
    random_batch(60);
    drain();

    // armed but not enabled, then enabled but not armed
    set_zone(0, 1, 2560, 2560, 12800, 12800);
    random_batch(30);
    drain();
    set_zone(1, 0, 2560, 2560, 12800, 12800);
    random_batch(30);
    drain();
    set_zone(1, 1, -100, -100, 100, 100);
    random_batch(80);
    drain();

    $display("Sent %0d moves, checked %0d results over eight zone settings,",
             sent, checked);
    $display("with sender and receiver stalls and one long output hold-off.");
    if (errors == 0 && expected_clips.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
